// ===== rtl/dhfk_pkg.sv =====
`default_nettype none
package dhfk_pkg;

  // Angle and length widths
  localparam int ANGLE_BITS  = 16;
  localparam int LENGTH_BITS = 32;
  localparam int IN_ANG_W    = 16;
  localparam int ANG_SUM_W   = 25;

  // Shared multiplier operand width and product width
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  localparam logic signed [MW-1:0] ONE_Q30     = MW'(64'sd1073741824);
  localparam logic signed [MW-1:0] HALF_PI_Q30 = MW'(64'sd1686629713);
  localparam logic [ANGLE_BITS-1:0] QUARTER    = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam logic signed [PW-1:0] POS_MAX = PW'((65'sd1 <<< (LENGTH_BITS - 1)) - 65'sd1);
  localparam logic signed [PW-1:0] POS_MIN = -POS_MAX - PW'(1);
  localparam logic signed [PW-1:0] I32_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] I32_MIN = PW'(-64'sd2147483648);
  localparam logic signed [PW-1:0] ONE_W   = PW'(64'sd1073741824);

  typedef logic signed [MW-1:0] opnd_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic [IN_ANG_W-1:0] fixed_angle;
    logic [IN_ANG_W-1:0] joint_angle;
    logic signed [31:0]  offset_d;
    logic signed [31:0]  length_a;
    logic [IN_ANG_W-1:0] twist_alpha;
    logic                last_link;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_X,
    ST_SIN_X2,
    ST_SIN_T,
    ST_SIN_D,
    ST_SIN_F,
    ST_DH,
    ST_POS,
    ST_ROT,
    ST_DONE
  } state_e;

  // Round half away from zero, then shift right by s
  function automatic prod_t rnd_shift(input prod_t v, input int s);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r   = (mag + (PW'(1) << (s - 1))) >> s;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic prod_t clamp(input prod_t v, input prod_t lo, input prod_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic opnd_t sx32(input logic signed [31:0] v);
    return {{(MW-32){v[31]}}, v};
  endfunction

  // Taylor term divisor k*(k+1), k = 12 down to 2 in steps of 2
  function automatic logic [7:0] term_div(input logic [2:0] t);
    case (t)
      3'd0:    return 8'd156;
      3'd1:    return 8'd110;
      3'd2:    return 8'd72;
      3'd3:    return 8'd42;
      3'd4:    return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  // floor(2^34 / divisor)
  function automatic opnd_t term_recip(input logic [2:0] t);
    case (t)
      3'd0:    return MW'(64'd110127366);
      3'd1:    return MW'(64'd156180628);
      3'd2:    return MW'(64'd238609294);
      3'd3:    return MW'(64'd409044504);
      3'd4:    return MW'(64'd858993459);
      default: return MW'(64'd2863311530);
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dhfk_mul.sv =====
`default_nettype none
module dhfk_mul
  import dhfk_pkg::*;
(
  input  wire logic  clk_i,
  input  wire opnd_t a_i,
  input  wire opnd_t b_i,
  output prod_t      p_o
);

  // Signed multiply, product registered
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

// ===== rtl/dh_forward_kinematics_chain.sv =====
// Sequencing: an accepted link occupies the block (in_stall_o high) until it is done; a result
//   is registered once its last link is done (later if the output is stalled).
// Flow: one link at a time, no new link until the last is through, set by the single shared
//   multiplier doing 102 dependent products in turn (four sines, DH terms, 3x4 product).
// Reset (rst_ni low, async): running transform returns to identity, position to
//   zero, sequencer idle, output empty.
`default_nettype none
module dh_forward_kinematics_chain
  import dhfk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  state_e state_q, state_d;
  logic   ph_q;

  logic [1:0] ai_q;
  logic [2:0] t_q;
  logic [2:0] idx_q;
  logic [1:0] i_q, j_q, k_q;

  logic [ANGLE_BITS-1:0] theta_q, alpha_q;
  logic signed [31:0]    d_q, a_q;
  logic                  last_q;

  opnd_t       x_q, x2_q, acc_q;
  logic [MW-1:0] mag_q;
  logic        neg_q;
  prod_t       sum_q;

  logic signed [31:0] trig_q [4];
  logic signed [31:0] dhm_q  [4];
  logic signed [31:0] pdm_q  [2];
  logic signed [31:0] rot_q  [9];
  logic signed [31:0] nr_q   [9];
  logic signed [LENGTH_BITS-1:0] pos_q [3];

  logic signed [31:0] dh_w [9];
  logic signed [31:0] pd_w [3];

  out_item_t out_q;
  logic      out_valid_q;

  opnd_t mul_a, mul_b;
  prod_t prod;

  dhfk_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // DH matrix and translation from stored terms
  always_comb begin
    dh_w[0] = trig_q[1];
    dh_w[1] = dhm_q[0];
    dh_w[2] = dhm_q[1];
    dh_w[3] = trig_q[0];
    dh_w[4] = dhm_q[2];
    dh_w[5] = dhm_q[3];
    dh_w[6] = '0;
    dh_w[7] = trig_q[2];
    dh_w[8] = trig_q[3];
    pd_w[0] = pdm_q[0];
    pd_w[1] = pdm_q[1];
    pd_w[2] = d_q;
  end

  // Angle reduction for the current sine
  logic [ANGLE_BITS-1:0] ang;
  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] rr;
  always_comb begin
    ang  = (ai_q[1] ? alpha_q : theta_q) + (ai_q[0] ? QUARTER : '0);
    quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
    rr   = {1'b0, ang[ANGLE_BITS-3:0]};
    if (quad[0]) rr = {1'b1, {(ANGLE_BITS-2){1'b0}}} - rr;
  end

  logic [3:0] ik, kj, ij;
  assign ik = 4'({i_q, 1'b0}) + 4'(i_q) + 4'(k_q);
  assign kj = 4'({k_q, 1'b0}) + 4'(k_q) + 4'(j_q);
  assign ij = 4'({i_q, 1'b0}) + 4'(i_q) + 4'(j_q);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = x_q;
    mul_b = acc_q;
    case (state_q)
      ST_SIN_X: begin
        mul_a = $signed({{(MW-ANGLE_BITS+1){1'b0}}, rr});
        mul_b = HALF_PI_Q30;
      end
      ST_SIN_X2: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_SIN_T: begin
        mul_a = x2_q;
        mul_b = acc_q;
      end
      ST_SIN_D: begin
        mul_a = $signed(mag_q);
        mul_b = term_recip(t_q);
      end
      ST_DH: begin
        case (idx_q)
          3'd0:    begin mul_a = sx32(trig_q[0]); mul_b = sx32(trig_q[3]); end
          3'd1:    begin mul_a = sx32(trig_q[0]); mul_b = sx32(trig_q[2]); end
          3'd2:    begin mul_a = sx32(trig_q[1]); mul_b = sx32(trig_q[3]); end
          3'd3:    begin mul_a = sx32(trig_q[1]); mul_b = sx32(trig_q[2]); end
          3'd4:    begin mul_a = sx32(a_q);       mul_b = sx32(trig_q[1]); end
          default: begin mul_a = sx32(a_q);       mul_b = sx32(trig_q[0]); end
        endcase
      end
      ST_POS: begin
        mul_a = sx32(rot_q[ik]);
        mul_b = sx32(pd_w[k_q]);
      end
      ST_ROT: begin
        mul_a = sx32(rot_q[ik]);
        mul_b = sx32(dh_w[kj]);
      end
      default: begin
        mul_a = x_q;
        mul_b = acc_q;
      end
    endcase
  end

  // Post-processing of the registered product
  prod_t         r30, rx, sum_n, sin_v, pos_n, dh_r;
  logic [MW-1:0] q0, qq;
  logic [MW+7:0] qd, rem;
  logic [7:0]    dv;
  opnd_t         acc_n;
  always_comb begin
    r30   = rnd_shift(prod, 30);
    rx    = rnd_shift(prod, ANGLE_BITS - 2);
    sum_n = sum_q + prod;
    dv    = term_div(t_q);
    q0    = prod[PW-1:34];
    qd    = q0 * dv;
    rem   = (MW+8)'(mag_q) - qd;
    qq    = (rem >= (MW+8)'(dv)) ? q0 + MW'(1) : q0;
    acc_n = neg_q ? ONE_Q30 + $signed(qq) : ONE_Q30 - $signed(qq);
    sin_v = clamp(r30, '0, ONE_W);
    if (quad[1]) sin_v = -sin_v;
    dh_r  = rnd_shift(sum_n, 30);
    pos_n = clamp(PW'(pos_q[i_q]) + dh_r, POS_MIN, POS_MAX);
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SIN_X;
      ST_SIN_X:  if (ph_q) state_d = ST_SIN_X2;
      ST_SIN_X2: if (ph_q) state_d = ST_SIN_T;
      ST_SIN_T:  if (ph_q) state_d = ST_SIN_D;
      ST_SIN_D:  if (ph_q) state_d = (t_q == 3'd5) ? ST_SIN_F : ST_SIN_T;
      ST_SIN_F:  if (ph_q) state_d = (ai_q == 2'd3) ? ST_DH : ST_SIN_X;
      ST_DH:     if (ph_q && idx_q == 3'd5) state_d = ST_POS;
      ST_POS:    if (ph_q && k_q == 2'd2 && i_q == 2'd2) state_d = ST_ROT;
      ST_ROT:    if (ph_q && k_q == 2'd2 && i_q == 2'd2 && j_q == 2'd2) state_d = ST_DONE;
      ST_DONE:   if (!last_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // State and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
      ai_q    <= '0;
      t_q     <= '0;
      idx_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE || state_q == ST_DONE) begin
        ph_q  <= 1'b0;
        ai_q  <= '0;
        t_q   <= '0;
        idx_q <= '0;
        i_q   <= '0;
        j_q   <= '0;
        k_q   <= '0;
      end else begin
        ph_q <= !ph_q;
        if (ph_q) begin
          case (state_q)
            ST_SIN_X2: t_q <= '0;
            ST_SIN_D:  t_q <= t_q + 3'd1;
            ST_SIN_F:  ai_q <= ai_q + 2'd1;
            ST_DH:     idx_q <= idx_q + 3'd1;
            ST_POS: begin
              k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
              if (k_q == 2'd2) i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
            end
            ST_ROT: begin
              k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
              if (k_q == 2'd2) begin
                j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
                if (j_q == 2'd2) i_q <= i_q + 2'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Running transform and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 9; n++) rot_q[n] <= (n % 4 == 0) ? 32'sd1073741824 : 32'sd0;
      for (int n = 0; n < 3; n++) pos_q[n] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result valid: set on a new pose, cleared once its transfer is taken
      if (state_q == ST_DONE && last_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_POS && ph_q && k_q == 2'd2) pos_q[i_q] <= LENGTH_BITS'(pos_n);
      if (state_q == ST_DONE) begin
        if (!last_q) begin
          for (int n = 0; n < 9; n++) rot_q[n] <= nr_q[n];
        end else if (out_free) begin
          out_q.end_x <= 32'(clamp(PW'(pos_q[0]), I32_MIN, I32_MAX));
          out_q.end_y <= 32'(clamp(PW'(pos_q[1]), I32_MIN, I32_MAX));
          out_q.end_z <= 32'(clamp(PW'(pos_q[2]), I32_MIN, I32_MAX));
          for (int n = 0; n < 9; n++) rot_q[n] <= (n % 4 == 0) ? 32'sd1073741824 : 32'sd0;
          for (int n = 0; n < 3; n++) pos_q[n] <= '0;
        end
      end
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      theta_q <= ANGLE_BITS'(ANG_SUM_W'(in_data_i.fixed_angle)
                             + ANG_SUM_W'(in_data_i.joint_angle));
      alpha_q <= ANGLE_BITS'(ANG_SUM_W'(in_data_i.twist_alpha));
      d_q     <= in_data_i.offset_d;
      a_q     <= in_data_i.length_a;
      last_q  <= in_data_i.last_link;
      sum_q   <= '0;
    end
    if (ph_q) begin
      case (state_q)
        ST_SIN_X:  x_q <= rx[MW-1:0];
        ST_SIN_X2: begin
          x2_q  <= r30[MW-1:0];
          acc_q <= ONE_Q30;
        end
        ST_SIN_T: begin
          neg_q <= r30[PW-1];
          mag_q <= r30[PW-1] ? MW'(-r30) : MW'(r30);
        end
        ST_SIN_D:  acc_q <= acc_n;
        ST_SIN_F:  trig_q[ai_q] <= sin_v[31:0];
        ST_DH: begin
          case (idx_q)
            3'd0:    dhm_q[0] <= 32'(-r30);
            3'd1:    dhm_q[1] <= 32'(r30);
            3'd2:    dhm_q[2] <= 32'(r30);
            3'd3:    dhm_q[3] <= 32'(-r30);
            3'd4:    pdm_q[0] <= 32'(clamp(r30, I32_MIN, I32_MAX));
            default: pdm_q[1] <= 32'(clamp(r30, I32_MIN, I32_MAX));
          endcase
        end
        ST_POS: sum_q <= (k_q == 2'd2) ? '0 : sum_n;
        ST_ROT: begin
          sum_q <= (k_q == 2'd2) ? '0 : sum_n;
          if (k_q == 2'd2) nr_q[ij] <= 32'(clamp(dh_r, -ONE_W, ONE_W));
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
